// ===== rtl/afrf_pkg.sv =====
// ----------------------------------------------------------------------------
// afrf_pkg
// Shared constants and types for the audio frame ring fifo.
// ----------------------------------------------------------------------------
package afrf_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 8;
  localparam int unsigned MAX_FRAMES_DEF   = 2048;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned FRAMES_W  = 12;
  localparam int unsigned CHANS_W   = 4;
  localparam int unsigned CHAN_W    = 3;
  localparam int unsigned RES_LIMIT = 8;
  localparam int unsigned S_DATA_W  = 40;
  localparam int unsigned M_DATA_W  = 40;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic CFG_RING_FRAMES = 1'b0;
  localparam logic CFG_CAPTURE_CH  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_RD_REQ,
    ST_RD_OUT
  } afrf_state_e;

endpackage

// ===== rtl/audio_frame_ring_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// audio_frame_ring_fifo_unit
// Ring of multichannel audio frames held in one synchronous sample memory.
// ----------------------------------------------------------------------------
// write transfer: taken while idle, ready again next cycle; an end-of-frame write
//   first zero-pads each remaining channel, then commits the frame
// read transfer: accepted while idle, then per channel result a memory read, then
//   output hold until taken; the memory read port is registered
// reset clears control registers and pointers; the sample memory and read data register are not cleared
module audio_frame_ring_fifo_unit
  import afrf_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int unsigned MAX_FRAMES   = MAX_FRAMES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [FRAMES_W-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // sample[31:0], out_channels[35:32], zero fill
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  input  logic                s_axis_tlast,
  // cmd[0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // sample_out[31:0], channel[34:32], zero fill
  output logic [M_DATA_W-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  // from_ring[0]
  output logic                m_axis_tuser
);

  localparam int unsigned SLOT_W = $clog2(MAX_FRAMES);
  localparam int unsigned CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned ADDR_W = SLOT_W + CH_W;
  localparam int unsigned DEPTH  = MAX_FRAMES << CH_W;
  localparam int unsigned CMP_W  = (SLOT_W + 1 > FRAMES_W) ? SLOT_W + 1 : FRAMES_W;
  localparam logic [16:0] MAX_FR = 17'(MAX_FRAMES);
  localparam logic [5:0]  MAX_CH = 6'(MAX_CHANNELS);

  afrf_state_e         state_q, state_d;
  logic [FRAMES_W-1:0] rf_q;
  logic [CHANS_W-1:0]  cc_q;
  logic [SLOT_W-1:0]   wslot_q, wslot_d;
  logic [SLOT_W-1:0]   rslot_q, rslot_d;
  logic [FRAMES_W-1:0] fill_q, fill_d;
  logic [CHANS_W-1:0]  wch_q, wch_d;
  logic [CHANS_W-1:0]  rch_q, rch_d;
  logic [CHANS_W-1:0]  want_q, want_d;
  logic                have_q, have_d;
  logic [SAMPLE_W-1:0] rdata_q;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [SAMPLE_W-1:0] mem_wdata;

  logic [FRAMES_W-1:0] rf_eff;
  logic [CHANS_W-1:0]  cc_eff;
  logic [CMP_W-1:0]    rf_ext, ws_inc, rs_inc;
  logic [SLOT_W-1:0]   wslot_nxt, rslot_nxt;
  logic [4:0]          wch_ext, rch_ext;
  logic [CHANS_W-1:0]  rch_inc;
  logic [SAMPLE_W-1:0] in_sample;
  logic [CHANS_W-1:0]  in_want;
  logic                s_xfer, from_ring;

  assign rf_eff = ({5'd0, rf_q} > MAX_FR) ? MAX_FR[FRAMES_W-1:0] : rf_q;
  assign cc_eff = ({2'd0, cc_q} > MAX_CH) ? MAX_CH[CHANS_W-1:0] : cc_q;

  assign rf_ext    = CMP_W'(rf_eff);
  assign ws_inc    = CMP_W'(wslot_q) + CMP_W'(1);
  assign rs_inc    = CMP_W'(rslot_q) + CMP_W'(1);
  assign wslot_nxt = (ws_inc >= rf_ext) ? '0 : ws_inc[SLOT_W-1:0];
  assign rslot_nxt = (rs_inc >= rf_ext) ? '0 : rs_inc[SLOT_W-1:0];

  assign wch_ext   = {1'b0, wch_q};
  assign rch_ext   = {1'b0, rch_q};
  assign rch_inc   = rch_q + 4'd1;
  assign mem_waddr = {wslot_q, wch_ext[CH_W-1:0]};
  assign mem_raddr = {rslot_q, rch_ext[CH_W-1:0]};

  assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
  assign in_want   = s_axis_tdata[SAMPLE_W+CHANS_W-1:SAMPLE_W];
  assign s_xfer    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d       = state_q;
    wslot_d       = wslot_q;
    rslot_d       = rslot_q;
    fill_d        = fill_q;
    wch_d         = wch_q;
    rch_d         = rch_q;
    want_d        = want_q;
    have_d        = have_q;
    mem_we        = 1'b0;
    mem_wdata     = in_sample;
    mem_re        = 1'b0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_xfer) begin
          if (s_axis_tuser == CMD_WRITE) begin
            if (rf_eff != '0 && cc_eff != '0) begin
              if (wch_q == '0 && fill_q >= rf_eff) begin
                rslot_d = rslot_nxt;
                fill_d  = fill_q - 12'd1;
              end
              if (wch_q < cc_eff) begin
                mem_we = 1'b1;
                wch_d  = wch_q + 4'd1;
              end
              if (s_axis_tlast) begin
                state_d = ST_PAD;
              end
            end
          end else begin
            want_d = (in_want > 4'(RES_LIMIT)) ? 4'(RES_LIMIT) : in_want;
            have_d = (rf_eff != '0) && (fill_q != '0);
            rch_d  = '0;
            if (want_d == '0) begin
              if (have_d) begin
                rslot_d = rslot_nxt;
                fill_d  = fill_q - 12'd1;
              end
            end else begin
              state_d = ST_RD_REQ;
            end
          end
        end
      end
      ST_PAD: begin
        if (wch_q < cc_eff) begin
          mem_we    = 1'b1;
          mem_wdata = '0;
          wch_d     = wch_q + 4'd1;
        end else begin
          wslot_d = wslot_nxt;
          if (fill_q < rf_eff) begin
            fill_d = fill_q + 12'd1;
          end
          wch_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_RD_REQ: begin
        mem_re  = 1'b1;
        state_d = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          rch_d = rch_inc;
          if (rch_inc == want_q) begin
            if (have_q) begin
              rslot_d = rslot_nxt;
              fill_d  = fill_q - 12'd1;
            end
            state_d = ST_IDLE;
          end else begin
            state_d = ST_RD_REQ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) begin
      wslot_d = '0;
      rslot_d = '0;
      fill_d  = '0;
      wch_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rf_q    <= '0;
      cc_q    <= '0;
      wslot_q <= '0;
      rslot_q <= '0;
      fill_q  <= '0;
      wch_q   <= '0;
      rch_q   <= '0;
      want_q  <= '0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wslot_q <= wslot_d;
      rslot_q <= rslot_d;
      fill_q  <= fill_d;
      wch_q   <= wch_d;
      rch_q   <= rch_d;
      want_q  <= want_d;
      have_q  <= have_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RING_FRAMES: rf_q <= cfg_data_i;
          CFG_CAPTURE_CH:  cc_q <= cfg_data_i[CHANS_W-1:0];
          default:         rf_q <= rf_q;
        endcase
      end
    end
  end

  // sample memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign from_ring     = have_q && (rch_q < cc_eff);
  assign m_axis_tdata  = {5'd0, rch_q[CHAN_W-1:0], (from_ring ? rdata_q : '0)};
  assign m_axis_tlast  = (rch_inc == want_q);
  assign m_axis_tuser  = from_ring;

endmodule
